// File: rtl/core/fbpdq_pkg.sv
// Shared constants, codes and types for the frame buffer pool core.
`default_nettype none
package fbpdq_pkg;
    localparam int BUFS_PER_CLASS = 8;
    localparam int NUM_CLASSES    = 2;
    localparam int TOTAL_BUFS     = 16;

    localparam int ID_W   = $clog2(TOTAL_BUFS);
    localparam int POS_W  = $clog2(BUFS_PER_CLASS);
    localparam int CLS_W  = ID_W - POS_W;
    localparam int FCNT_W = $clog2(BUFS_PER_CLASS + 1);
    localparam int FILL_W = $clog2(TOTAL_BUFS + 1);
    localparam int SIZE_W = 24;
    localparam int SEQ_W  = 32;
    localparam int REC_W  = 4;
    localparam int CMD_W  = 2;
    localparam int POL_W  = 2;
    localparam int IDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    localparam logic [1:0] OWN_FREE  = 2'd0;
    localparam logic [1:0] OWN_PROD  = 2'd1;
    localparam logic [1:0] OWN_READY = 2'd2;
    localparam logic [1:0] OWN_CONS  = 2'd3;

    localparam logic [POL_W-1:0] POL_OLDEST = 2'd0;
    localparam logic [POL_W-1:0] POL_KEY    = 2'd1;

    localparam logic [IDX_W-1:0] REG_SMALL = 2'd0;
    localparam logic [IDX_W-1:0] REG_LARGE = 2'd1;
    localparam logic [IDX_W-1:0] REG_POL   = 2'd2;
    localparam logic [IDX_W-1:0] REG_ALLOW = 2'd3;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_EXEC  = 3'd1;
    localparam logic [2:0] OP_SCAN  = 3'd2;
    localparam logic [2:0] OP_DROP  = 3'd3;
    localparam logic [2:0] OP_DELIV = 3'd4;
    localparam logic [2:0] OP_LOAD  = 3'd5;

    typedef struct packed {
        logic       in_ready;
        logic [2:0] op;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_valid;
        logic cons_go;
        logic cons_scan;
        logic scan_last;
        logic drop_zero;
        logic out_free;
    } t_dp_status;
endpackage
`default_nettype wire

// File: rtl/core/fbpdq_ifs.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface fbpdq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] request_size;
    logic [3:0]  buf_id;
    logic [23:0] payload_len;
    logic        key_frame;
    modport source(output valid, cmd, request_size, buf_id, payload_len, key_frame,
                   input ready);
    modport sink(input valid, cmd, request_size, buf_id, payload_len, key_frame,
                 output ready);
endinterface

interface fbpdq_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [3:0]  buf_out;
    logic        class_out;
    logic [23:0] buf_capacity;
    logic [23:0] length_out;
    logic        key_out;
    logic [31:0] seq_out;
    logic [3:0]  recycled;
    logic [4:0]  queued;
    modport source(output valid, ok, buf_out, class_out, buf_capacity, length_out,
                   key_out, seq_out, recycled, queued, input ready);
    modport sink(input valid, ok, buf_out, class_out, buf_capacity, length_out,
                 key_out, seq_out, recycled, queued, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fbpdq_ctrl.sv
// Sequencer for one transaction: execute, scan, drop loop, deliver, output.
`default_nettype none
module fbpdq_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire fbpdq_pkg::t_dp_status i_st,
    output fbpdq_pkg::t_ctl_cmd        o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DROP  = 3'd3;
    localparam logic [2:0] S_DELIV = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = fbpdq_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_st.in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.op = fbpdq_pkg::OP_EXEC;
                if (!i_st.cons_go) n_state = S_OUT;
                else if (i_st.cons_scan) n_state = S_SCAN;
                else n_state = S_DROP;
            end
            S_SCAN: begin
                o_cmd.op = fbpdq_pkg::OP_SCAN;
                if (i_st.scan_last) n_state = S_DROP;
            end
            S_DROP: begin
                if (i_st.drop_zero) n_state = S_DELIV;
                else o_cmd.op = fbpdq_pkg::OP_DROP;
            end
            S_DELIV: begin
                o_cmd.op = fbpdq_pkg::OP_DELIV;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.op = fbpdq_pkg::OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule
`default_nettype wire

// File: rtl/core/fbpdq_dp.sv
// Pool state, free lists, ready ring, frame metadata and output register.
`default_nettype none
module fbpdq_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire fbpdq_pkg::t_ctl_cmd   i_cmd,
    output fbpdq_pkg::t_dp_status      o_st,
    fbpdq_in_if.sink                   i_in,
    fbpdq_out_if.source                o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [fbpdq_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fbpdq_pkg::SIZE_W-1:0] i_cfg_data
);
    localparam int ID_W   = fbpdq_pkg::ID_W;
    localparam int POS_W  = fbpdq_pkg::POS_W;
    localparam int CLS_W  = fbpdq_pkg::CLS_W;
    localparam int FCNT_W = fbpdq_pkg::FCNT_W;
    localparam int FILL_W = fbpdq_pkg::FILL_W;
    localparam int SIZE_W = fbpdq_pkg::SIZE_W;
    localparam int SEQ_W  = fbpdq_pkg::SEQ_W;
    localparam int NCL    = fbpdq_pkg::NUM_CLASSES;
    localparam int NBUF   = fbpdq_pkg::TOTAL_BUFS;

    // configuration
    logic [SIZE_W-1:0] r_small, r_large;
    logic [1:0]        r_pol;
    logic              r_allow;

    // latched transaction
    logic [1:0]        r_opc;
    logic [SIZE_W-1:0] r_req, r_len;
    logic [ID_W-1:0]   r_id;
    logic              r_key;

    // pool state
    logic [ID_W-1:0]   r_flist [NBUF];
    logic [POS_W-1:0]  r_fhead [NCL];
    logic [FCNT_W-1:0] r_fcnt  [NCL];
    logic [1:0]        r_own   [NBUF];
    logic [ID_W-1:0]   r_ring  [NBUF];
    logic [ID_W-1:0]   r_rhead;
    logic [FILL_W-1:0] r_fill;
    logic [SIZE_W-1:0] r_flen  [NBUF];
    logic              r_fkey  [NBUF];
    logic [SEQ_W-1:0]  r_fseq  [NBUF];
    logic [SEQ_W-1:0]  r_nseq;

    // consume sequencing
    logic [FILL_W-1:0] r_k, r_drop;
    logic [3:0]        r_n;

    // staged result
    logic              r_ok, r_cls, r_kout;
    logic [ID_W-1:0]   r_bout;
    logic [SIZE_W-1:0] r_cap, r_lout;
    logic [SEQ_W-1:0]  r_sout;

    // output register
    logic              r_ov;

    logic              w_acc;
    logic              a_hit, a_done;
    logic [CLS_W-1:0]  a_sel;
    logic [SIZE_W-1:0] a_cap;
    logic [CLS_W-1:0]  id_cls;
    logic [SIZE_W-1:0] id_cap;
    logic              commit_ok, release_ok;
    logic              push_en;
    logic [ID_W-1:0]   push_id;
    logic [CLS_W-1:0]  push_cls;
    logic [POS_W-1:0]  push_pos;
    logic [ID_W-1:0]   pop_id;
    logic [ID_W-1:0]   scan_id;
    logic              is_exec, is_drop, is_deliv, is_scan;

    function automatic logic [SIZE_W-1:0] f_cap(input logic [CLS_W-1:0] c,
                                                input logic [SIZE_W-1:0] s,
                                                input logic [SIZE_W-1:0] l);
        return (c == '0) ? s : l;
    endfunction

    assign w_acc    = i_in.valid && i_cmd.in_ready;
    assign i_in.ready = i_cmd.in_ready;
    assign is_exec  = (i_cmd.op == fbpdq_pkg::OP_EXEC);
    assign is_scan  = (i_cmd.op == fbpdq_pkg::OP_SCAN);
    assign is_drop  = (i_cmd.op == fbpdq_pkg::OP_DROP);
    assign is_deliv = (i_cmd.op == fbpdq_pkg::OP_DELIV);

    // acquire: first class that fits, optionally falling through when empty
    always_comb begin
        logic [SIZE_W-1:0] cap;
        a_hit  = 1'b0;
        a_done = 1'b0;
        a_sel  = '0;
        for (int c = 0; c < NCL; c++) begin
            cap = f_cap(CLS_W'(c), r_small, r_large);
            if (!a_done && cap >= r_req) begin
                if (r_fcnt[c] != '0) begin
                    a_hit  = 1'b1;
                    a_sel  = CLS_W'(c);
                    a_done = 1'b1;
                end else if (!r_allow) begin
                    a_done = 1'b1;
                end
            end
        end
        a_cap = f_cap(a_sel, r_small, r_large);
    end

    assign id_cls     = r_id[ID_W-1:POS_W];
    assign id_cap     = f_cap(id_cls, r_small, r_large);
    assign commit_ok  = (r_own[r_id] == fbpdq_pkg::OWN_PROD) &&
                        (r_fill < FILL_W'(NBUF)) && (r_len <= id_cap);
    assign release_ok = (r_own[r_id] == fbpdq_pkg::OWN_PROD) ||
                        (r_own[r_id] == fbpdq_pkg::OWN_CONS);

    assign pop_id  = r_ring[r_rhead];
    assign scan_id = r_ring[r_rhead + r_k[ID_W-1:0]];

    // one free-list append per cycle: dropped frame or released buffer
    always_comb begin
        push_en = 1'b0;
        push_id = r_id;
        if (is_drop) begin
            push_en = 1'b1;
            push_id = pop_id;
        end else if (is_exec && r_opc == fbpdq_pkg::CMD_RELEASE && release_ok) begin
            push_en = 1'b1;
        end
        push_cls = push_id[ID_W-1:POS_W];
        push_pos = r_fhead[push_cls] + r_fcnt[push_cls][POS_W-1:0];
        if (r_fcnt[push_cls] >= FCNT_W'(fbpdq_pkg::BUFS_PER_CLASS)) push_en = 1'b0;
    end

    assign o_st.in_valid  = i_in.valid;
    assign o_st.cons_go   = (r_opc == fbpdq_pkg::CMD_CONSUME) && (r_fill != '0);
    assign o_st.cons_scan = (r_pol == fbpdq_pkg::POL_KEY);
    assign o_st.scan_last = (r_k == r_fill - FILL_W'(1));
    assign o_st.drop_zero = (r_drop == '0);
    assign o_st.out_free  = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small <= SIZE_W'(1024);
            r_large <= SIZE_W'(4096);
            r_pol   <= 2'd2;
            r_allow <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fbpdq_pkg::REG_SMALL: r_small <= i_cfg_data;
                fbpdq_pkg::REG_LARGE: r_large <= i_cfg_data;
                fbpdq_pkg::REG_POL:   r_pol   <= i_cfg_data[1:0];
                fbpdq_pkg::REG_ALLOW: r_allow <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_opc <= i_in.cmd;
            r_req <= i_in.request_size;
            r_id  <= i_in.buf_id;
            r_len <= i_in.payload_len;
            r_key <= i_in.key_frame;
        end
    end

    // pool bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NBUF; b++) begin
                r_flist[b] <= ID_W'(b);
                r_own[b]   <= fbpdq_pkg::OWN_FREE;
            end
            for (int c = 0; c < NCL; c++) begin
                r_fhead[c] <= '0;
                r_fcnt[c]  <= FCNT_W'(fbpdq_pkg::BUFS_PER_CLASS);
            end
            r_rhead <= '0;
            r_fill  <= '0;
            r_nseq  <= '0;
            r_k     <= '0;
            r_drop  <= '0;
            r_n     <= '0;
        end else begin
            if (push_en) begin
                r_flist[{push_cls, push_pos}] <= push_id;
                r_fcnt[push_cls] <= r_fcnt[push_cls] + FCNT_W'(1);
                r_own[push_id]   <= fbpdq_pkg::OWN_FREE;
            end
            if (is_exec) begin
                r_k <= '0;
                r_n <= '0;
                r_drop <= (r_pol == fbpdq_pkg::POL_OLDEST || r_pol == fbpdq_pkg::POL_KEY)
                          ? '0 : r_fill - FILL_W'(1);
                case (r_opc)
                    fbpdq_pkg::CMD_ACQUIRE: begin
                        if (a_hit) begin
                            r_fhead[a_sel] <= r_fhead[a_sel] + POS_W'(1);
                            r_fcnt[a_sel]  <= r_fcnt[a_sel] - FCNT_W'(1);
                            r_own[r_flist[{a_sel, r_fhead[a_sel]}]] <= fbpdq_pkg::OWN_PROD;
                        end
                    end
                    fbpdq_pkg::CMD_COMMIT: begin
                        if (commit_ok) begin
                            r_flen[r_id] <= r_len;
                            r_fkey[r_id] <= r_key;
                            r_fseq[r_id] <= r_nseq;
                            r_nseq       <= r_nseq + SEQ_W'(1);
                            r_ring[r_rhead + r_fill[ID_W-1:0]] <= r_id;
                            r_fill       <= r_fill + FILL_W'(1);
                            r_own[r_id]  <= fbpdq_pkg::OWN_READY;
                        end
                    end
                    default: ;
                endcase
            end
            if (is_scan) begin
                if (r_fkey[scan_id]) r_drop <= r_k;
                r_k <= r_k + FILL_W'(1);
            end
            if (is_drop) begin
                r_rhead <= r_rhead + ID_W'(1);
                r_fill  <= r_fill - FILL_W'(1);
                r_drop  <= r_drop - FILL_W'(1);
                r_n     <= r_n + 4'd1;
            end
            if (is_deliv) begin
                r_rhead <= r_rhead + ID_W'(1);
                r_fill  <= r_fill - FILL_W'(1);
                r_own[pop_id] <= fbpdq_pkg::OWN_CONS;
            end
        end
    end

    // staged result fields
    always_ff @(posedge i_clk) begin
        if (is_exec) begin
            r_ok   <= 1'b0;
            r_bout <= '0;
            r_cls  <= 1'b0;
            r_cap  <= '0;
            r_lout <= '0;
            r_kout <= 1'b0;
            r_sout <= '0;
            case (r_opc)
                fbpdq_pkg::CMD_ACQUIRE: begin
                    if (a_hit) begin
                        r_ok   <= 1'b1;
                        r_bout <= r_flist[{a_sel, r_fhead[a_sel]}];
                        r_cls  <= a_sel[0];
                        r_cap  <= a_cap;
                    end
                end
                fbpdq_pkg::CMD_COMMIT:  r_ok <= commit_ok;
                fbpdq_pkg::CMD_RELEASE: r_ok <= release_ok;
                default: ;
            endcase
        end else if (is_deliv) begin
            r_ok   <= 1'b1;
            r_bout <= pop_id;
            r_cls  <= pop_id[POS_W];
            r_lout <= r_flen[pop_id];
            r_kout <= r_fkey[pop_id];
            r_sout <= r_fseq[pop_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == fbpdq_pkg::OP_LOAD) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fbpdq_pkg::OP_LOAD) begin
            o_out.ok           <= r_ok;
            o_out.buf_out      <= r_bout;
            o_out.class_out    <= r_cls;
            o_out.buf_capacity <= r_cap;
            o_out.length_out   <= r_lout;
            o_out.key_out      <= r_kout;
            o_out.seq_out      <= r_sout;
            o_out.recycled     <= r_n;
            o_out.queued       <= r_fill;
        end
    end

    assign o_out.valid = r_ov;
endmodule
`default_nettype wire

// File: rtl/core/frame_buffer_pool_drop_queue_core.sv
// Top level of the frame buffer pool with drop-policy ready queue.
// Command channel i_in (valid/ready): acquire, commit, consume or release,
// one transaction at a time. Result channel o_out (valid/ready): exactly one
// result transaction per command, in command order.
// Config port: i_cfg_we writes register i_cfg_idx (0 small size, 1 large size,
// 2 drop policy, 3 allow larger class) with i_cfg_data; the user must write
// only while idle, as the block itself does not enforce it.
// Acquire, commit, release and an empty-queue consume run the execute and
// output steps only. Consume otherwise drops the recycled frames one by one,
// after a scan of every queued frame in keyframe catch-up, then delivers one.
// With the receiver ready, a new command can be taken in the same cycle as
// the previous result goes valid.
// The sequencer handles one command end to end; the next command is taken
// once the previous result sits in the output register, so a stalled
// receiver holds at most one waiting result and one command in progress.
// If o_out.ready stays low, the finished result parks until the register
// frees, and i_in.ready stays low meanwhile.
// Reset (i_rst_n low, synchronous): all buffers free in ascending order per
// class, ready queue empty, sequence number 0, registers at their defaults.
`default_nettype none
module frame_buffer_pool_drop_queue_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    fbpdq_in_if.sink                               i_in,
    fbpdq_out_if.source                            o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [fbpdq_pkg::IDX_W-1:0]       i_cfg_idx,
    input  wire logic [fbpdq_pkg::SIZE_W-1:0]      i_cfg_data
);
    fbpdq_pkg::t_ctl_cmd   w_cmd;
    fbpdq_pkg::t_dp_status w_st;

    // control: walks each transaction through its steps
    fbpdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    // datapath: free lists, ready ring, metadata, result register
    fbpdq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );
endmodule
`default_nettype wire

// File: rtl/core/fbpdq_chk.sv
// Port-level checker for the frame buffer pool core, with its bind.
`default_nettype none
module fbpdq_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_ok,
    input wire logic [3:0]  i_buf_out,
    input wire logic [3:0]  i_recycled,
    input wire logic [31:0] i_seq_out,
    input wire logic [4:0]  i_queued
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command taken while one in progress");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ok |-> i_buf_out == 4'd0 && i_recycled == 4'd0 &&
                                 i_seq_out == 32'd0)
        else $error("failed result carries data");

    a_queued_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_queued <= 5'd16)
        else $error("queue fill beyond pool size");
endmodule

bind frame_buffer_pool_drop_queue_core fbpdq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ok        (o_out.ok),
    .i_buf_out   (o_out.buf_out),
    .i_recycled  (o_out.recycled),
    .i_seq_out   (o_out.seq_out),
    .i_queued    (o_out.queued)
);
`default_nettype wire
